FILE: rtl/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg
// Types and codes shared by the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int SIZE_W = 16;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_NEXT  = 2'd2;
    localparam logic [1:0] POL_WORST = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [2:0]        partition_index;
        logic [SIZE_W-1:0] size_value;
    } in_t;

    typedef struct packed {
        logic       granted;
        logic [2:0] granted_index;
    } out_t;

    typedef struct packed {
        logic ge;
        logic lt;
        logic gt;
    } cmp_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

endpackage

FILE: rtl/fpfa_cmp.sv
// ----------------------------------------------------------------------------
// fpfa_cmp
// Shared size comparator: candidate against request and against current pick.
// ----------------------------------------------------------------------------
module fpfa_cmp (
    input  logic [fpfa_pkg::SIZE_W-1:0] cand,
    input  logic [fpfa_pkg::SIZE_W-1:0] req,
    input  logic [fpfa_pkg::SIZE_W-1:0] pick,
    output fpfa_pkg::cmp_res_t          res
);
    import fpfa_pkg::*;

    always_comb
    begin
        res.ge = (cand >= req);
        res.lt = (cand < pick);
        res.gt = (cand > pick);
    end

endmodule

FILE: rtl/fpfa_size_mem.sv
// ----------------------------------------------------------------------------
// fpfa_size_mem
// Partition size store, one write and one registered read port.
// Entries not yet loaded read as zero.
// ----------------------------------------------------------------------------
module fpfa_size_mem #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [IDX_W-1:0]            waddr,
    input  logic [fpfa_pkg::SIZE_W-1:0] wdata,
    input  logic [IDX_W-1:0]            raddr,
    output logic [fpfa_pkg::SIZE_W-1:0] rdata
);
    import fpfa_pkg::*;

    logic [SIZE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [SIZE_W-1:0] rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/fixed_partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition table with first, best, next and worst fit placement.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on cmd at a clock edge with start high and busy
//   low. Every transaction gives one result on result, marked by done for
//   exactly one cycle; the receiver cannot stall, so it must sample then.
//   Load, clear and unused actions answer in the next cycle and leave busy
//   low, so they may be issued back to back.
//   An allocate walks the size table one partition per cycle through the
//   single read port of the size store, feeding one shared comparator;
//   busy stays high through the scan and commit states and falls in the
//   same cycle that done rises, and no transaction is taken while busy.
//   cfg_we writes the fit policy; write it only while idle.
//   Reset clears the size table (through per-entry valid bits), all
//   occupied marks, the next-fit pointer and the policy; no clearing pass.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator #(
    parameter int PARTITION_COUNT = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  fpfa_pkg::in_t  cmd,
    output logic           done,
    output fpfa_pkg::out_t result,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_wdata
);
    import fpfa_pkg::*;

    localparam int IDX_W = (PARTITION_COUNT > 1) ? $clog2(PARTITION_COUNT) : 1;
    localparam int CNT_W = $clog2(PARTITION_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTITION_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(PARTITION_COUNT);

    state_t                 state_reg, state_next;
    logic [1:0]             pol_reg;
    logic [PARTITION_COUNT-1:0] occ_reg, occ_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [SIZE_W-1:0]      req_reg, req_next;
    logic [IDX_W-1:0]       addr_reg, addr_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   eval_reg, eval_next;
    logic [IDX_W-1:0]       eval_idx_reg, eval_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       pick_idx_reg, pick_idx_next;
    logic [SIZE_W-1:0]      pick_size_reg, pick_size_next;
    logic                   done_reg, done_next;
    out_t                   result_reg, result_next;

    logic                   accept;
    logic                   ld_we;
    logic [IDX_W+2:0]       ld_wide;
    logic [IDX_W-1:0]       ld_addr;
    logic [IDX_W+2:0]       pick_wide;
    logic [SIZE_W-1:0]      cand_size;
    cmp_res_t               cmp;
    logic                   take;

    assign accept  = start && (state_reg == ST_IDLE);
    assign ld_wide = (IDX_W + 3)'(cmd.partition_index);
    assign ld_addr = ld_wide[IDX_W-1:0];
    assign ld_we   = accept && (cmd.action == ACT_LOAD)
                     && (32'(cmd.partition_index) < PARTITION_COUNT);
    assign pick_wide = (IDX_W + 3)'(pick_idx_reg);

    fpfa_size_mem #(
        .DEPTH (PARTITION_COUNT),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ld_we),
        .waddr (ld_addr),
        .wdata (cmd.size_value),
        .raddr (addr_reg),
        .rdata (cand_size)
    );

    fpfa_cmp u_cmp (
        .cand (cand_size),
        .req  (req_reg),
        .pick (pick_size_reg),
        .res  (cmp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pol_reg    <= POL_FIRST;
            occ_reg    <= '0;
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            eval_reg   <= 1'b0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            ptr_reg    <= ptr_next;
            cnt_reg    <= cnt_next;
            eval_reg   <= eval_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            if (cfg_we)
            begin
                pol_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        addr_reg      <= addr_next;
        eval_idx_reg  <= eval_idx_next;
        pick_idx_reg  <= pick_idx_next;
        pick_size_reg <= pick_size_next;
    end

    // candidate fits and beats current pick under the policy
    always_comb
    begin
        take = eval_reg && !occ_reg[eval_idx_reg] && cmp.ge
               && (!found_reg
                   || ((pol_reg == POL_BEST) && cmp.lt)
                   || ((pol_reg == POL_WORST) && cmp.gt));
    end

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        ptr_next       = ptr_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        eval_next      = 1'b0;
        eval_idx_next  = addr_reg;
        found_next     = found_reg;
        pick_idx_next  = pick_idx_reg;
        pick_size_next = pick_size_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next = '0;
                    case (cmd.action)
                        ACT_LOAD:
                        begin
                            done_next = 1'b1;
                            if (ld_we)
                            begin
                                occ_next[ld_addr] = 1'b0;
                            end
                        end
                        ACT_ALLOC:
                        begin
                            state_next = ST_SCAN;
                            req_next   = cmd.size_value;
                            addr_next  = (pol_reg == POL_NEXT) ? ptr_reg : '0;
                            cnt_next   = '0;
                            found_next = 1'b0;
                        end
                        ACT_CLEAR:
                        begin
                            done_next = 1'b1;
                            occ_next  = '0;
                            ptr_next  = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    found_next     = 1'b1;
                    pick_idx_next  = eval_idx_reg;
                    pick_size_next = cand_size;
                end
                if (cnt_reg != CNT_END)
                begin
                    eval_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    addr_next = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                result_next = '0;
                if (found_reg)
                begin
                    occ_next[pick_idx_reg]    = 1'b1;
                    result_next.granted       = 1'b1;
                    result_next.granted_index = pick_wide[2:0];
                    if (pol_reg == POL_NEXT)
                    begin
                        ptr_next = pick_idx_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/fpfa_checker.sv
// ----------------------------------------------------------------------------
// fpfa_checker
// Port-level timing checks for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
module fpfa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input fpfa_pkg::in_t  cmd,
    input logic           done,
    input fpfa_pkg::out_t result
);
    import fpfa_pkg::*;

    // refused allocation reports index zero
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.granted |-> result.granted_index == 3'd0)
        else $error("ungranted result with non-zero index");

    // non-allocate transactions answer next cycle, never granted
    a_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.action != ACT_ALLOC) |=> done && !result.granted)
        else $error("non-allocate transaction not answered in one cycle");

    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.action == ACT_ALLOC) |=> busy && !done)
        else $error("allocate did not start a scan");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("scan ended without a result");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (.*);

FILE: sim/fixed_partition_fit_allocator_tb.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_tb
// Self-checking bench for the fixed partition fit allocator. A queue-fed
// driver issues load, allocate, clear and unused-action transactions with
// random gaps; a monitor checks every result against an internal placement
// predictor. Covers all four fit policies, ties, wrap, zero-size requests
// and requests that cannot be placed.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_tb;
    import fpfa_pkg::*;

    localparam int         NPART      = 8;
    localparam int         DRAIN_CYC  = NPART + 4;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    in_t        cmd = '0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_wdata = '0;
    logic       busy;
    logic       done;
    out_t       result;

    in_t  pending_cmds[$];
    out_t expected_results[$];
    int   fail_count = 0;
    bit   gaps_on = 1'b1;

    // predictor state
    logic [15:0]      part_size[NPART];
    logic [NPART-1:0] part_taken = '0;
    logic [2:0]       nf_ptr = '0;
    logic [1:0]       fit_policy = POL_FIRST;

    out_t want;

    fixed_partition_fit_allocator #(
        .PARTITION_COUNT(NPART)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic out_t place_request(in_t c);
        out_t        r;
        int          pick;
        logic [2:0]  idx;
        logic [2:0]  base;
        r    = '0;
        pick = -1;
        case (c.action)
            ACT_LOAD:
            begin
                part_size[c.partition_index]  = c.size_value;
                part_taken[c.partition_index] = 1'b0;
            end
            ACT_CLEAR:
            begin
                part_taken = '0;
                nf_ptr     = '0;
            end
            ACT_ALLOC:
            begin
                if (fit_policy == POL_FIRST || fit_policy == POL_NEXT)
                begin
                    base = (fit_policy == POL_NEXT) ? nf_ptr : 3'd0;
                    for (int k = 0; k < NPART; k++)
                    begin
                        idx = base + k[2:0];
                        if (pick < 0 && !part_taken[idx] && part_size[idx] >= c.size_value)
                            pick = idx;
                    end
                end
                else
                begin
                    for (int i = 0; i < NPART; i++)
                    begin
                        if (!part_taken[i] && part_size[i] >= c.size_value &&
                            (pick < 0 ||
                             (fit_policy == POL_BEST  && part_size[i] < part_size[pick]) ||
                             (fit_policy == POL_WORST && part_size[i] > part_size[pick])))
                            pick = i;
                    end
                end
                if (pick >= 0)
                begin
                    part_taken[pick] = 1'b1;
                    if (fit_policy == POL_NEXT)
                        nf_ptr = pick[2:0];
                    r.granted       = 1'b1;
                    r.granted_index = pick[2:0];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // driver: start is held until the transaction is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(place_request(cmd));
                void'(pending_cmds.pop_front());
            end
            if (!(start && busy))
            begin
                if (pending_cmds.size() != 0 &&
                    !(gaps_on && $urandom_range(0, 99) < 23))
                begin
                    start <= 1'b1;
                    cmd   <= pending_cmds[0];
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with none expected: granted %0d granted_index %0d",
                       result.granted, result.granted_index);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.granted !== want.granted)
                begin
                    $error("granted: expected %0d, got %0d", want.granted, result.granted);
                    fail_count++;
                end
                if (result.granted_index !== want.granted_index)
                begin
                    $error("granted_index: expected %0d, got %0d",
                           want.granted_index, result.granted_index);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_cmd(logic [1:0] act, logic [2:0] idx, logic [15:0] sz);
        in_t c;
        c.action          = act;
        c.partition_index = idx;
        c.size_value      = sz;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_policy(logic [1:0] p);
        wait_drained();
        cfg_we     <= 1'b1;
        cfg_wdata  <= p;
        fit_policy  = p;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random(int n);
        int          roll;
        logic [15:0] sz;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                sz = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 8) * 64);
                push_cmd(ACT_LOAD, 3'($urandom_range(0, 7)), sz);
            end
            else if (roll < 85)
            begin
                sz = ($urandom_range(0, 99) < 15) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 520));
                push_cmd(ACT_ALLOC, 3'($urandom_range(0, 7)), sz);
            end
            else if (roll < 93)
            begin
                push_cmd(ACT_CLEAR, 3'($urandom_range(0, 7)),
                         16'($urandom_range(0, 65535)));
            end
            else
            begin
                push_cmd(ACT_UNUSED, 3'($urandom_range(0, 7)),
                         16'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < NPART; i++)
            part_size[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first fit, reset policy
        push_cmd(ACT_LOAD, 3'd0, 16'hFFFF);
        push_cmd(ACT_LOAD, 3'd7, 16'd0);
        push_cmd(ACT_LOAD, 3'd3, 16'd100);
        push_cmd(ACT_LOAD, 3'd5, 16'd100);
        push_cmd(ACT_ALLOC, 3'd0, 16'd0);
        push_cmd(ACT_ALLOC, 3'd7, 16'd100);
        push_cmd(ACT_ALLOC, 3'd0, 16'hFFFF);
        push_cmd(ACT_UNUSED, 3'd7, 16'hFFFF);
        push_cmd(ACT_ALLOC, 3'd0, 16'd0);
        push_cmd(ACT_CLEAR, 3'd0, 16'd0);

        // best fit, tie on the two 100 entries
        write_policy(POL_BEST);
        push_cmd(ACT_ALLOC, 3'd0, 16'd50);
        push_cmd(ACT_ALLOC, 3'd0, 16'd50);
        push_cmd(ACT_ALLOC, 3'd0, 16'd50);

        // next fit, pointer moves then fails to wrap onto anything
        write_policy(POL_NEXT);
        push_cmd(ACT_CLEAR, 3'd0, 16'd0);
        push_cmd(ACT_ALLOC, 3'd0, 16'd0);
        push_cmd(ACT_ALLOC, 3'd0, 16'd0);
        push_cmd(ACT_LOAD, 3'd1, 16'd300);
        push_cmd(ACT_ALLOC, 3'd0, 16'd200);
        push_cmd(ACT_ALLOC, 3'd0, 16'd100);
        push_cmd(ACT_ALLOC, 3'd0, 16'd100);
        push_cmd(ACT_ALLOC, 3'd0, 16'd100);

        // worst fit with a tie
        write_policy(POL_WORST);
        push_cmd(ACT_CLEAR, 3'd0, 16'd0);
        push_cmd(ACT_ALLOC, 3'd0, 16'd1);
        push_cmd(ACT_LOAD, 3'd2, 16'd300);
        push_cmd(ACT_ALLOC, 3'd0, 16'd1);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_policy((ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3)));
            gaps_on = (ph != 2);
            queue_random(105);
        end

        wait_drained();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
